[src/bitmap_id_allocator_top_defines.svh]
// Assertion macros used by the checker.
`ifndef BITMAP_ID_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define BMID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BMID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bmid_pkg.sv]
package bmid_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned TDATA_W = 16;

  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FREE  = 4'b1000
  } state_t;

  function automatic logic [BIT_W-1:0] lowest_zero(input logic [BYTE_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[src/bitmap_id_allocator_top.sv]
// Identifier allocator over a bitmap of used marks held in one synchronous memory.
// Input channel: in_tuser selects the request (0 allocate, 1 free), in_tdata carries
// the identifier to free. A free gives no result; a free of an
// identifier at or above ID_COUNT is ignored.
// Result channel: one transaction per allocate, out_tdata holds the granted identifier
// and out_tuser is set when no identifier was free (out_tdata is then zero).
// An allocate starts at a kept low-water byte below which every byte is known full,
// reads one mark byte per cycle through the memory port and takes the lowest clear bit.
// Full bytes are passed over until a byte with room or the last byte is read.
// One request is in flight at a time.
// The result sits in an output register, so the next request is taken while it waits.
// A finished allocate holds in the scan stage until the output register is free, so a
// stalled receiver stalls only the following allocate, never loses a result.
// After reset the block clears the memory, one byte a cycle, with in_tready low;
// then every identifier is free.
module bitmap_id_allocator_top #(
  parameter int ID_COUNT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bmid_pkg::TDATA_W-1:0] in_tdata,   // [9:0] release_id, [15:10] zero
  input  logic                         in_tuser,   // [0] mode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bmid_pkg::TDATA_W-1:0] out_tdata,  // [9:0] granted_id, [15:10] zero
  output logic                         out_tuser   // [0] none_free
);
  import bmid_pkg::*;

  localparam int MARK_BYTES = (ID_COUNT + 7) / 8;
  localparam int IDX_W      = (MARK_BYTES > 1) ? $clog2(MARK_BYTES) : 1;
  localparam int FULL_W     = IDX_W + BIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MARK_BYTES - 1);

  logic [BYTE_W-1:0] mem [MARK_BYTES];
  logic [BYTE_W-1:0] rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_wdata;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  hint_r, hint_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              fvalid_r, fvalid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_none_r, out_none_nxt;

  logic [ID_W-1:0]   rel_id;
  logic              rel_in_range;
  logic [IDX_W-1:0]  rel_byte;
  logic              slot_ok;
  logic              byte_full;
  logic [BIT_W-1:0]  low_zero_bit;
  logic [FULL_W-1:0] cand_id;
  logic              cand_ok;

  assign rel_id       = in_tdata[ID_W-1:0];
  assign rel_in_range = {22'd0, rel_id} < 32'(ID_COUNT);
  assign rel_byte     = rel_in_range ? IDX_W'(rel_id[ID_W-1:BIT_W]) : '0;
  assign slot_ok      = !out_valid_r || out_tready;
  assign byte_full    = rdata_r == FULL_BYTE;
  assign low_zero_bit = lowest_zero(rdata_r);
  assign cand_id      = {idx_r, low_zero_bit};
  assign cand_ok      = 32'(cand_id) < 32'(ID_COUNT);

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_id_r};
  assign out_tuser  = out_none_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hint_nxt      = hint_r;
    bit_nxt       = bit_r;
    fvalid_nxt    = fvalid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_none_nxt  = out_none_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    mem_raddr     = idx_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == MODE_FREE) begin
            idx_nxt    = rel_byte;
            bit_nxt    = rel_id[BIT_W-1:0];
            fvalid_nxt = rel_in_range;
            mem_raddr  = rel_byte;
            state_nxt  = ST_FREE;
          end else begin
            idx_nxt   = hint_r;
            mem_raddr = hint_r;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_FREE: begin
        mem_we    = fvalid_r;
        mem_wdata = rdata_r & ~(BYTE_W'(1) << bit_r);
        if (fvalid_r && (idx_r < hint_r)) begin
          hint_nxt = idx_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (!byte_full || (idx_r == LAST_IDX)) begin
          if (slot_ok) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (!byte_full && cand_ok) begin
              mem_we       = 1'b1;
              mem_wdata    = rdata_r | (BYTE_W'(1) << low_zero_bit);
              hint_nxt     = idx_r;
              out_id_nxt   = ID_W'(cand_id);
              out_none_nxt = 1'b0;
            end else begin
              out_id_nxt   = '0;
              out_none_nxt = 1'b1;
            end
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          mem_raddr = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      hint_r      <= '0;
      fvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hint_r      <= hint_nxt;
      fvalid_r    <= fvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r      <= bit_nxt;
    out_id_r   <= out_id_nxt;
    out_none_r <= out_none_nxt;
  end

endmodule

[src/bmid_checker.sv]
`include "bitmap_id_allocator_top_defines.svh"

module bmid_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [bmid_pkg::TDATA_W-1:0] out_tdata,
  input logic                         out_tuser
);
  import bmid_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  `BMID_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid, "Result dropped while stalled.")
  `BMID_ASSERT(a_out_stable, clk, rst_n, out_stall |=> $stable(out_tdata) && $stable(out_tuser), "Result changed while stalled.")
  `BMID_ASSERT(a_full_zero, clk, rst_n, (out_tvalid && out_tuser) |-> (out_tdata == '0), "A failed allocation carries a nonzero identifier.")
  `BMID_ASSERT(a_one_at_a_time, clk, rst_n, in_acc |=> !in_tready, "A second request was taken while one is in flight.")
  `BMID_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !in_tready && !out_tvalid, "Block not quiet after reset.")

endmodule

bind bitmap_id_allocator_top bmid_checker u_bmid_checker (.*);
